// ----- rtl/lc3_instruction_executor_macros.svh -----
// Assertion macros for the LC-3 executor checker.
// Included by lc3_exec_checker.sv; no other dependencies.
`ifndef LC3_INSTRUCTION_EXECUTOR_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTOR_MACROS_SVH
// implication checked every clock outside reset
`define LC3_ASSERT_IMP(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (c)) else $error(msg);
// implication checked in the next cycle
`define LC3_ASSERT_NXT(lbl, clk, rstn, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (c)) else $error(msg);
`endif

// ----- rtl/lc3_pkg.sv -----
// Shared types and constants for the LC-3 executor.
// No dependencies.
`default_nettype none
package lc3_pkg;
  localparam int MEM_WORDS = 65536;
  localparam int MEM_AW = $clog2(MEM_WORDS);

  localparam logic [2:0] CMD_WRMEM = 3'd0;
  localparam logic [2:0] CMD_RDMEM = 3'd1;
  localparam logic [2:0] CMD_WRREG = 3'd2;
  localparam logic [2:0] CMD_KEY   = 3'd3;
  localparam logic [2:0] CMD_STEP  = 3'd4;

  localparam logic [3:0] OP_BR  = 4'd0;
  localparam logic [3:0] OP_ADD = 4'd1;
  localparam logic [3:0] OP_LD  = 4'd2;
  localparam logic [3:0] OP_ST  = 4'd3;
  localparam logic [3:0] OP_JSR = 4'd4;
  localparam logic [3:0] OP_AND = 4'd5;
  localparam logic [3:0] OP_LDR = 4'd6;
  localparam logic [3:0] OP_STR = 4'd7;
  localparam logic [3:0] OP_NOT = 4'd9;
  localparam logic [3:0] OP_LDI = 4'd10;
  localparam logic [3:0] OP_STI = 4'd11;
  localparam logic [3:0] OP_JMP = 4'd12;
  localparam logic [3:0] OP_LEA = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [15:0] KB_STATUS = 16'hFE00;
  localparam logic [15:0] KB_DATA   = 16'hFE02;
  localparam logic [15:0] KB_READY  = 16'h8000;
  localparam logic [7:0]  HALT_VEC  = 8'h25;
  localparam logic [15:0] PC_RESET  = 16'h3000;

  localparam logic [3:0] REG_PC = 4'd8;
  localparam logic [3:0] REG_FLAGS = 4'd9;

  // memory port source for address
  localparam logic [1:0] MA_IN  = 2'd0;
  localparam logic [1:0] MA_PC  = 2'd1;
  localparam logic [1:0] MA_EA  = 2'd2;
  localparam logic [1:0] MA_RD  = 2'd3;

  typedef struct packed {
    logic       load_in;    // latch request fields
    logic       load_ir;    // latch fetched word as instruction
    logic       mem_re;     // start a memory read
    logic [1:0] mem_asel;
    logic       mem_we;     // write memory
    logic       wdata_reg;  // write data from register DR, else request data
    logic       do_wrreg;   // register write command
    logic       do_key;     // key arrival
    logic       exec;       // execute non-memory part / compute effective address
    logic       load_dr;    // write DR from memory read data
    logic       load_ea;    // latch read data as indirect address
    logic       emit;       // drive result strobe
    logic       rd_result;  // result_data from memory read
  } lc3_cmd_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic [3:0] op;
    logic       stopped;
  } lc3_stat_t;

  function automatic logic [2:0] nzp(input logic [15:0] v);
    if (v == 16'd0) return 3'd2;
    else if (v[15]) return 3'd4;
    else return 3'd1;
  endfunction
endpackage
`default_nettype wire

// ----- rtl/lc3_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module lc3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/lc3_datapath.sv -----
// LC-3 datapath: registers, PC, flags, keyboard latch and the word memory.
// Depends on lc3_pkg and lc3_ram.
`default_nettype none
module lc3_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire lc3_pkg::lc3_cmd_t ctl,
  output lc3_pkg::lc3_stat_t     stat,
  input  wire logic [2:0]        in_cmd,
  input  wire logic [15:0]       in_addr,
  input  wire logic [15:0]       in_data,
  output logic                   out_valid,
  output logic [15:0]            out_result_data,
  output logic [15:0]            out_pc,
  output logic [2:0]             out_cond,
  output logic                   out_halted,
  output logic                   out_trap_taken,
  output logic [7:0]             out_trap_vector,
  output logic                   out_illegal_opcode
);
  import lc3_pkg::*;

  logic [2:0]  cmd_r;
  logic [15:0] addr_r, data_r, ir_r, ea_r;
  logic [15:0] regs_r [8];
  logic [15:0] pc_r;
  logic [2:0]  flags_r;
  logic        stopped_r, key_pend_r;
  logic [7:0]  key_r;
  logic        trap_r, ill_r;
  logic [7:0]  vec_r;
  logic [15:0] res_r;
  logic        valid_r;

  logic [15:0] mem_rdata, mem_a16, mem_wdata, off9, off6, off11, imm5, sr1v, opnd, alu;
  logic [15:0] kbd_word;
  logic        kbd_hit, mem_we, at_stat, at_data;
  logic [MEM_AW-1:0] mem_a;
  logic [3:0]  op;
  logic [2:0]  dr, sr1;

  assign op  = ir_r[15:12];
  assign dr  = ir_r[11:9];
  assign sr1 = ir_r[8:6];
  assign off9  = {{7{ir_r[8]}}, ir_r[8:0]};
  assign off6  = {{10{ir_r[5]}}, ir_r[5:0]};
  assign off11 = {{5{ir_r[10]}}, ir_r[10:0]};
  assign imm5  = {{11{ir_r[4]}}, ir_r[4:0]};
  assign sr1v  = regs_r[sr1];
  assign opnd  = ir_r[5] ? imm5 : regs_r[ir_r[2:0]];
  assign alu   = (op == OP_ADD) ? sr1v + opnd : sr1v & opnd;

  always_comb begin
    case (ctl.mem_asel)
      MA_IN:   mem_a16 = addr_r;
      MA_PC:   mem_a16 = pc_r;
      MA_EA:   mem_a16 = ea_r;
      default: mem_a16 = mem_rdata;
    endcase
  end

  // The keyboard status and data words are held in registers beside the
  // RAM; a read of either address is answered from them in the next cycle.
  // A read of the status address refreshes the status word, and the data
  // word if a key is pending; the RAM port is never needed for the keyboard.
  assign kbd_hit = ctl.mem_re && (mem_a16 == KB_STATUS);
  always_comb begin
    mem_we    = ctl.mem_we;
    mem_wdata = ctl.wdata_reg ? regs_r[dr] : data_r;
    mem_a     = mem_a16[MEM_AW-1:0];
    kbd_word  = key_pend_r ? KB_READY : 16'd0;
  end
  assign at_stat = (mem_a == KB_STATUS[MEM_AW-1:0]);
  assign at_data = (mem_a == KB_DATA[MEM_AW-1:0]);

  logic        kbd_byp_r;
  logic [15:0] kbd_stat_r, kbd_dat_r, kbd_q_r;
  logic [15:0] rdata;
  logic [15:0] ram_q;
  lc3_ram #(.WIDTH(16), .DEPTH(MEM_WORDS)) u_ram (
    .clk(clk), .we(mem_we), .addr(mem_a), .wdata(mem_wdata), .rdata(ram_q));
  assign rdata = kbd_byp_r ? kbd_q_r : ram_q;
  assign mem_rdata = rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) regs_r[i] <= 16'd0;
      pc_r <= PC_RESET; flags_r <= 3'd0; stopped_r <= 1'b0;
      key_pend_r <= 1'b0; key_r <= 8'd0; valid_r <= 1'b0;
      kbd_byp_r <= 1'b0; kbd_stat_r <= 16'd0; kbd_dat_r <= 16'd0; kbd_q_r <= 16'd0;
      trap_r <= 1'b0; ill_r <= 1'b0; vec_r <= 8'd0; res_r <= 16'd0;
    end else begin
      valid_r <= ctl.emit;
      kbd_byp_r <= ctl.mem_re && (at_stat || at_data);
      if (ctl.mem_re) kbd_q_r <= kbd_hit ? kbd_word : (at_stat ? kbd_stat_r : kbd_dat_r);
      if (kbd_hit) begin
        kbd_stat_r <= kbd_word;
        if (key_pend_r) begin
          key_pend_r <= 1'b0;
          kbd_dat_r <= {8'd0, key_r};
        end
      end
      if (mem_we && at_stat) kbd_stat_r <= mem_wdata;
      if (mem_we && at_data) kbd_dat_r <= mem_wdata;
      if (ctl.load_in) begin
        cmd_r <= in_cmd; addr_r <= in_addr; data_r <= in_data;
        trap_r <= 1'b0; ill_r <= 1'b0; vec_r <= 8'd0; res_r <= 16'd0;
      end
      if (ctl.rd_result) res_r <= rdata;
      if (ctl.do_key) begin
        key_pend_r <= 1'b1; key_r <= data_r[7:0];
      end
      if (ctl.do_wrreg) begin
        if (addr_r < 16'd8) regs_r[addr_r[2:0]] <= data_r;
        else if (addr_r == {12'd0, REG_PC}) pc_r <= data_r;
        else if (addr_r == {12'd0, REG_FLAGS}) flags_r <= data_r[2:0];
      end
      if (ctl.load_ir) begin
        ir_r <= rdata;
        pc_r <= pc_r + 16'd1;
        ea_r <= pc_r + 16'd1;
      end
      if (ctl.load_ea) ea_r <= rdata;
      if (ctl.load_dr) begin
        regs_r[dr] <= rdata; flags_r <= nzp(rdata);
      end
      if (ctl.exec) begin
        case (op)
          OP_ADD, OP_AND: begin regs_r[dr] <= alu; flags_r <= nzp(alu); end
          OP_NOT: begin regs_r[dr] <= ~sr1v; flags_r <= nzp(~sr1v); end
          OP_BR: if ((dr & flags_r) != 3'd0) pc_r <= pc_r + off9;
          OP_JMP: pc_r <= sr1v;
          OP_JSR: begin
            regs_r[7] <= pc_r;
            pc_r <= ir_r[11] ? pc_r + off11 : sr1v;
          end
          OP_LEA: begin regs_r[dr] <= pc_r + off9; flags_r <= nzp(pc_r + off9); end
          OP_LD, OP_LDI, OP_ST, OP_STI: ea_r <= pc_r + off9;
          OP_LDR, OP_STR: ea_r <= sr1v + off6;
          OP_TRAP: begin
            trap_r <= 1'b1; vec_r <= ir_r[7:0]; res_r <= regs_r[0];
            if (ir_r[7:0] == HALT_VEC) stopped_r <= 1'b1;
          end
          default: begin ill_r <= 1'b1; stopped_r <= 1'b1; end
        endcase
      end
    end
  end

  assign stat.cmd = cmd_r;
  assign stat.op = op;
  assign stat.stopped = stopped_r;

  assign out_valid = valid_r;
  assign out_result_data = res_r;
  assign out_pc = pc_r;
  assign out_cond = flags_r;
  assign out_halted = stopped_r;
  assign out_trap_taken = trap_r;
  assign out_trap_vector = vec_r;
  assign out_illegal_opcode = ill_r;
endmodule
`default_nettype wire

// ----- rtl/lc3_control.sv -----
// LC-3 sequencer: dispatches requests; steps go fetch, address, access, done.
// Depends on lc3_pkg.
`default_nettype none
module lc3_control (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire lc3_pkg::lc3_stat_t stat,
  output lc3_pkg::lc3_cmd_t      ctl
);
  import lc3_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_IR   = 3'd2;
  localparam logic [2:0] S_EA   = 3'd3;
  localparam logic [2:0] S_IND  = 3'd4;
  localparam logic [2:0] S_ACC  = 3'd5;
  localparam logic [2:0] S_WB   = 3'd6;
  localparam logic [2:0] S_RES  = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       is_ld, is_st;

  assign is_ld = stat.op == OP_LD || stat.op == OP_LDR || stat.op == OP_LDI;
  assign is_st = stat.op == OP_ST || stat.op == OP_STR || stat.op == OP_STI;

  always_comb begin
    ctl = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (start) begin ctl.load_in = 1'b1; state_nxt = S_DISP; end
      S_DISP: begin
        case (stat.cmd)
          CMD_WRMEM: begin ctl.mem_we = 1'b1; ctl.mem_asel = MA_IN; ctl.emit = 1'b1;
            state_nxt = S_IDLE; end
          CMD_RDMEM: begin ctl.mem_re = 1'b1; ctl.mem_asel = MA_IN; state_nxt = S_RES; end
          CMD_WRREG: begin ctl.do_wrreg = 1'b1; ctl.emit = 1'b1; state_nxt = S_IDLE; end
          CMD_KEY:   begin ctl.do_key = 1'b1; ctl.emit = 1'b1; state_nxt = S_IDLE; end
          CMD_STEP: begin
            if (stat.stopped) begin ctl.emit = 1'b1; state_nxt = S_IDLE; end
            else begin ctl.mem_re = 1'b1; ctl.mem_asel = MA_PC; state_nxt = S_IR; end
          end
          default: begin ctl.emit = 1'b1; state_nxt = S_IDLE; end
        endcase
      end
      S_RES: begin ctl.rd_result = 1'b1; ctl.emit = 1'b1; state_nxt = S_IDLE; end
      S_IR: begin ctl.load_ir = 1'b1; state_nxt = S_EA; end
      S_EA: begin
        ctl.exec = 1'b1;
        if (is_ld || is_st) state_nxt = S_IND;
        else begin ctl.emit = 1'b1; state_nxt = S_IDLE; end
      end
      S_IND: begin
        if (stat.op == OP_LDI || stat.op == OP_STI) begin
          ctl.mem_re = 1'b1; ctl.mem_asel = MA_EA; state_nxt = S_ACC;
        end else if (is_st) begin
          ctl.mem_we = 1'b1; ctl.wdata_reg = 1'b1; ctl.mem_asel = MA_EA;
          ctl.emit = 1'b1; state_nxt = S_IDLE;
        end else begin
          ctl.mem_re = 1'b1; ctl.mem_asel = MA_EA; state_nxt = S_WB;
        end
      end
      S_ACC: begin
        // pointer word is on read data
        if (stat.op == OP_STI) begin
          ctl.mem_we = 1'b1; ctl.wdata_reg = 1'b1; ctl.mem_asel = MA_RD;
          ctl.emit = 1'b1; state_nxt = S_IDLE;
        end else begin
          ctl.mem_re = 1'b1; ctl.mem_asel = MA_RD; state_nxt = S_WB;
        end
      end
      S_WB: begin ctl.load_dr = 1'b1; ctl.emit = 1'b1; state_nxt = S_IDLE; end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/lc3_instruction_executor.sv -----
// LC-3 executor top level: sequencer plus datapath.
// Depends on lc3_pkg, lc3_control, lc3_datapath.
`default_nettype none
// A request is taken when start is high and busy low. Its result appears on
// the out_ ports for one cycle with out_valid high; the receiver cannot stall
// it. The strobe comes in the last cycle of a request, and busy is already low
// then, so the next request can be taken at the edge that ends the strobe.
// Memory write, register write, key, unused command and a step while halted
// finish at dispatch; a memory read adds a result state. A step fetches and
// executes, then ST/STR store, LD/LDR read and write back, STI reads a pointer
// and stores, LDI reads a pointer and data and writes back: the single-port
// memory has registered read. Memory contents are undefined after reset.
module lc3_instruction_executor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_cmd,
  input  wire logic [15:0] in_addr,
  input  wire logic [15:0] in_data,
  output logic             out_valid,
  output logic [15:0]      out_result_data,
  output logic [15:0]      out_pc,
  output logic [2:0]       out_cond,
  output logic             out_halted,
  output logic             out_trap_taken,
  output logic [7:0]       out_trap_vector,
  output logic             out_illegal_opcode
);
  import lc3_pkg::*;
  lc3_cmd_t  ctl;
  lc3_stat_t stat;

  lc3_control u_ctrl (.clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .stat(stat), .ctl(ctl));

  lc3_datapath u_dp (.clk(clk), .rst_n(rst_n), .ctl(ctl), .stat(stat),
    .in_cmd(in_cmd), .in_addr(in_addr), .in_data(in_data),
    .out_valid(out_valid), .out_result_data(out_result_data), .out_pc(out_pc),
    .out_cond(out_cond), .out_halted(out_halted), .out_trap_taken(out_trap_taken),
    .out_trap_vector(out_trap_vector), .out_illegal_opcode(out_illegal_opcode));
endmodule
`default_nettype wire

// ----- rtl/lc3_exec_checker.sv -----
// Port-level checks for the LC-3 executor, bound to the top level.
// Depends on lc3_instruction_executor_macros.svh.
`default_nettype none
`include "lc3_instruction_executor_macros.svh"
module lc3_exec_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       out_valid,
  input wire logic       out_halted,
  input wire logic       out_trap_taken,
  input wire logic       out_illegal_opcode,
  input wire logic [7:0] out_trap_vector
);
  `LC3_ASSERT_NXT(a_acc_busy, clk, rst_n, start && !busy, busy, "no busy after request")
  `LC3_ASSERT_IMP(a_one_flag, clk, rst_n, out_valid, !(out_trap_taken && out_illegal_opcode), "trap and illegal both set")
  `LC3_ASSERT_IMP(a_ill_halt, clk, rst_n, out_valid && out_illegal_opcode, out_halted, "illegal without halt")
  `LC3_ASSERT_NXT(a_halt_sticky, clk, rst_n, out_halted, out_halted, "halt dropped")
  `LC3_ASSERT_IMP(a_vec_zero, clk, rst_n, out_valid && !out_trap_taken, out_trap_vector == 8'd0, "vector without trap")
endmodule
bind lc3_instruction_executor lc3_exec_checker u_chk (.clk(clk), .rst_n(rst_n),
  .start(start), .busy(busy), .out_valid(out_valid), .out_halted(out_halted),
  .out_trap_taken(out_trap_taken), .out_illegal_opcode(out_illegal_opcode),
  .out_trap_vector(out_trap_vector));
`default_nettype wire
